[hw/rtl/prp_pkg.sv]
// ----------------------------------------------------------------------------
// prp_pkg
// shared constants, codes and controller/datapath bundles for the rank engine
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int unsigned NODE_MAX = 1024;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned NCNT_W   = 11;
  localparam int unsigned EDGE_MAX = 8192;
  localparam int unsigned EDGE_W   = 13;
  localparam int unsigned ECNT_W   = 14;
  localparam int unsigned DIV_W    = 34;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned CFG_IW   = 8;

  localparam logic [CFG_IW-1:0] REG_NODE_COUNT = 8'd0;
  localparam logic [CFG_IW-1:0] REG_DAMPING    = 8'd1;
  localparam logic [CFG_IW-1:0] REG_TOLERANCE  = 8'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_ITER   = 8'd3;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_RUN   = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR,
    OP_ADD_CHK,
    OP_ADD_WR,
    OP_READ,
    OP_READ_DONE,
    OP_DIV_INIT,
    OP_DIV_BASE,
    OP_TAKE_BASE,
    OP_INIT_RANK,
    OP_PASS,
    OP_ACC_INIT,
    OP_E_RD,
    OP_E_GET,
    OP_E_MUL,
    OP_E_DIV,
    OP_E_ACC,
    OP_F_START,
    OP_F_RD,
    OP_F_CMP,
    OP_F_TAKE,
    OP_PASS_END,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  add_ok;
    logic  clr_last;
    logic  node_last;
    logic  nodes_done;
    logic  edges_left;
    logic  edge_skip;
    logic  deg_zero;
    logic  cmp_trivial;
    logic  div_busy;
    logic  run_stop;
  } dp_sts_t;

  function automatic logic [31:0] sat32(input logic [DIV_W:0] v);
    logic [31:0] r;
    r = (v > {{(DIV_W-31){1'b0}}, 32'hFFFF_FFFF}) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/pagerank_power_iteration.sv]
// ----------------------------------------------------------------------------
// pagerank_power_iteration
// edge list store and fixed point rank engine with one request in flight
// ----------------------------------------------------------------------------
// requests arrive on s_axis (tuser selects add edge, clear, run or read) and
// each gives exactly one response on m_axis. registers are written through
// the cfg channel, which is always ready and meant to be used while idle.
// an add edge that is refused skips the write step; a clear empties the edge
// list and sweeps the out-degree store to zero. the next request is taken in
// the cycle after the response is registered.
// a run sweeps the nodes and the stored edges once per pass, the shared
// serial divider (one quotient bit a cycle) setting most of its time, and
// repeats passes until it converges or reaches the pass limit. one request
// at a time.
// after reset the out-degree store, all 1024 entries, is swept to zero with
// s_axis_tready low. a response waits in the output register while the
// receiver stalls; the next request may already be accepted meanwhile.
// ----------------------------------------------------------------------------
module pagerank_power_iteration (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // node_a, node_b
  input  logic [1:0]                 s_axis_tuser,  // func
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [55:0]                m_axis_tdata,  // rank_value, iterations_used, converged
  output logic [1:0]                 m_axis_tuser,  // status
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [prp_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i
);
  import prp_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] rank_value;
  logic [15:0] iterations_used;
  logic        converged;

  assign cfg_ready_o = 1'b1;

  prp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  prp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_func_i        (s_axis_tuser),
    .in_a_i           (s_axis_tdata[NODE_W-1:0]),
    .in_b_i           (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rank_value_o     (rank_value),
    .iterations_used_o(iterations_used),
    .converged_o      (converged),
    .status_o         (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, converged, iterations_used, rank_value};

`ifndef SYNTHESIS
  a_conv_has_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[47:32] != 16'd0)
    else $error("converged reported with no pass done");

  a_rank_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |-> m_axis_tuser == ST_OK)
    else $error("rank value returned with error status");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");
`endif

endmodule

[hw/rtl/prp_div.sv]
// ----------------------------------------------------------------------------
// prp_div
// restoring divider, one quotient bit per cycle, with a preset partial remainder
// ----------------------------------------------------------------------------
module prp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [prp_pkg::DIV_W-1:0] rem_i,
  input  logic [prp_pkg::DIV_W-1:0] dvd_i,
  input  logic [prp_pkg::DIV_W-1:0] dvs_i,
  output logic                      busy_o,
  output logic [prp_pkg::DIV_W-1:0] quo_o
);
  import prp_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] shq_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, shq_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DIV_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      shq_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      shq_q <= {shq_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = shq_q;

endmodule

[hw/rtl/prp_datapath.sv]
// ----------------------------------------------------------------------------
// prp_datapath
// graph and rank stores, config registers, counters and arithmetic
// ----------------------------------------------------------------------------
module prp_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [prp_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  input  logic [1:0]                 in_func_i,
  input  logic [prp_pkg::NODE_W-1:0] in_a_i,
  input  logic [prp_pkg::NODE_W-1:0] in_b_i,
  input  prp_pkg::dp_cmd_t           cmd_i,
  output prp_pkg::dp_sts_t           sts_o,
  output logic [31:0]                rank_value_o,
  output logic [15:0]                iterations_used_o,
  output logic                       converged_o,
  output logic [1:0]                 status_o
);
  import prp_pkg::*;

  // config
  logic [NCNT_W-1:0] node_count_q;
  logic [15:0]       damping_q;
  logic [31:0]       tolerance_q;
  logic [15:0]       max_iter_q;

  // control
  logic [NCNT_W-1:0] i_q;
  logic [ECNT_W-1:0] e_q;
  logic [ECNT_W-1:0] total_q;
  logic [15:0]       iter_q;
  logic [15:0]       last_iter_q;
  logic              last_conv_q;

  // payload
  func_e             func_q;
  logic [NODE_W-1:0] a_q, b_q, s_q, t_q, node_q;
  status_e           status_q;
  logic [31:0]       rank_val_q, init_q, base_q, worst_q;
  logic [PROD_W-1:0] prod_q;
  logic [ECNT_W-1:0] deg_q;

  // stores
  logic [2*NODE_W-1:0] edge_mem [EDGE_MAX];
  logic [ECNT_W-1:0]   deg_mem  [NODE_MAX];
  logic [31:0]         rank_mem [NODE_MAX];
  logic [31:0]         acc_mem  [NODE_MAX];
  logic [2*NODE_W-1:0] edge_rd_q;
  logic [ECNT_W-1:0]   deg_rd_q;
  logic [31:0]         rank_rd_q, acc_rd_q;

  logic [NCNT_W-1:0] n_eff;
  logic [15:0]       limit;
  logic [NODE_W-1:0] i_idx, e_src, e_dst;
  logic              a_ok, b_ok;
  status_e           add_status;

  logic [31:0]       diff;
  logic [32:0]       sum;
  logic              trivial;
  logic [31:0]       chg_triv, chg_div;

  logic              div_start, div_busy;
  logic [DIV_W-1:0]  div_rem, div_dvd, div_dvs, quo;

  logic              rank_re, rank_we, deg_re, deg_we, acc_re, acc_we;
  logic [NODE_W-1:0] rank_ra, rank_wa, deg_ra, deg_wa, acc_ra, acc_wa;
  logic [31:0]       rank_wd, acc_wd;
  logic [ECNT_W-1:0] deg_wd;

  assign n_eff = (node_count_q == '0) ? NCNT_W'(1) :
                 (node_count_q > NCNT_W'(NODE_MAX)) ? NCNT_W'(NODE_MAX) : node_count_q;
  assign limit = (max_iter_q == '0) ? 16'd1 : max_iter_q;
  assign i_idx = i_q[NODE_W-1:0];
  assign e_src = edge_rd_q[NODE_W-1:0];
  assign e_dst = edge_rd_q[2*NODE_W-1:NODE_W];
  assign a_ok  = {1'b0, a_q} < n_eff;
  assign b_ok  = {1'b0, b_q} < n_eff;

  always_comb begin
    if (!a_ok || !b_ok) begin
      add_status = ST_BAD;
    end else if (total_q >= ECNT_W'(EDGE_MAX)) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_OK;
    end
  end

  assign diff     = (acc_rd_q > rank_rd_q) ? acc_rd_q - rank_rd_q : rank_rd_q - acc_rd_q;
  assign sum      = {1'b0, acc_rd_q} + {1'b0, rank_rd_q};
  assign trivial  = (acc_rd_q == '0) || (rank_rd_q == '0);
  assign chg_triv = (sum == '0) ? 32'd0 : 32'hFFFF_FFFF;
  assign chg_div  = sat32({2'b00, quo[DIV_W-1:1]});

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_dvd   = '0;
    div_dvs   = DIV_W'(1);
    unique case (cmd_i.op)
      OP_DIV_INIT: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(1) << 32;
        div_dvs   = DIV_W'(n_eff);
      end
      OP_DIV_BASE: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'({17'h10000 - {1'b0, damping_q}, 16'h0000});
        div_dvs   = DIV_W'(n_eff);
      end
      OP_E_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(prod_q[PROD_W-1:16]);
        div_dvs   = DIV_W'(deg_q);
      end
      OP_F_CMP: begin
        div_start = !trivial;
        div_rem   = DIV_W'(diff);
        div_dvs   = DIV_W'(sum);
      end
      default: begin
      end
    endcase
  end

  prp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .rem_i  (div_rem),
    .dvd_i  (div_dvd),
    .dvs_i  (div_dvs),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  // memory port selection
  always_comb begin
    rank_re = 1'b0; rank_ra = i_idx;
    rank_we = 1'b0; rank_wa = i_idx; rank_wd = init_q;
    deg_re  = 1'b0; deg_ra  = a_q;
    deg_we  = 1'b0; deg_wa  = i_idx; deg_wd  = '0;
    acc_re  = 1'b0; acc_ra  = i_idx;
    acc_we  = 1'b0; acc_wa  = i_idx; acc_wd  = base_q;
    unique case (cmd_i.op)
      OP_CLR:       deg_we = 1'b1;
      OP_ADD_CHK:   deg_re = 1'b1;
      OP_ADD_WR: begin
        deg_we = 1'b1;
        deg_wa = a_q;
        deg_wd = deg_rd_q + 1'b1;
      end
      OP_READ: begin
        rank_re = 1'b1;
        rank_ra = a_q;
      end
      OP_INIT_RANK: rank_we = 1'b1;
      OP_ACC_INIT:  acc_we  = 1'b1;
      OP_E_GET: begin
        rank_re = 1'b1;
        rank_ra = e_src;
        deg_re  = 1'b1;
        deg_ra  = e_src;
      end
      OP_E_MUL: begin
        acc_re = 1'b1;
        acc_ra = t_q;
      end
      OP_E_ACC: begin
        acc_we = 1'b1;
        acc_wa = t_q;
        acc_wd = sat32({3'b000, acc_rd_q} + {1'b0, quo});
      end
      OP_F_RD: begin
        rank_re = 1'b1;
        acc_re  = 1'b1;
      end
      OP_F_CMP: begin
        rank_we = 1'b1;
        rank_wa = node_q;
        rank_wd = acc_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ADD_WR) begin
      edge_mem[total_q[EDGE_W-1:0]] <= {b_q, a_q};
    end
    if (cmd_i.op == OP_E_RD) begin
      edge_rd_q <= edge_mem[e_q[EDGE_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (deg_re) begin
      deg_rd_q <= deg_mem[deg_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    if (rank_re) begin
      rank_rd_q <= rank_mem[rank_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_q <= acc_mem[acc_ra];
    end
  end

  // config and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NCNT_W'(1024);
      damping_q    <= 16'd55706;
      tolerance_q  <= 32'd4;
      max_iter_q   <= 16'd1000;
      i_q          <= '0;
      e_q          <= '0;
      total_q      <= '0;
      iter_q       <= '0;
      last_iter_q  <= '0;
      last_conv_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NODE_COUNT: node_count_q <= cfg_data_i[NCNT_W-1:0];
          REG_DAMPING:    damping_q    <= cfg_data_i[15:0];
          REG_TOLERANCE:  tolerance_q  <= cfg_data_i;
          REG_MAX_ITER:   max_iter_q   <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      unique case (cmd_i.op)
        OP_ACCEPT, OP_PASS, OP_F_START: begin
          i_q <= '0;
          e_q <= '0;
        end
        OP_TAKE_BASE: begin
          i_q    <= '0;
          iter_q <= '0;
        end
        OP_CLR: begin
          i_q     <= i_q + 1'b1;
          total_q <= '0;
        end
        OP_ADD_WR:                          total_q <= total_q + 1'b1;
        OP_INIT_RANK, OP_ACC_INIT, OP_F_RD: i_q     <= i_q + 1'b1;
        OP_E_RD:                            e_q     <= e_q + 1'b1;
        OP_PASS_END: begin
          iter_q      <= iter_q + 1'b1;
          last_iter_q <= iter_q + 1'b1;
          last_conv_q <= worst_q <= tolerance_q;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        func_q     <= func_e'(in_func_i);
        a_q        <= in_a_i;
        b_q        <= in_b_i;
        status_q   <= ST_OK;
        rank_val_q <= '0;
      end
      OP_ADD_CHK:   status_q   <= add_status;
      OP_READ:      status_q   <= a_ok ? ST_OK : ST_BAD;
      OP_READ_DONE: rank_val_q <= (status_q == ST_OK) ? rank_rd_q : 32'd0;
      OP_DIV_BASE:  init_q     <= sat32({1'b0, quo});
      OP_TAKE_BASE: base_q     <= sat32({1'b0, quo});
      OP_PASS:      worst_q    <= '0;
      OP_E_GET: begin
        s_q <= e_src;
        t_q <= e_dst;
      end
      OP_E_MUL: begin
        prod_q <= damping_q * rank_rd_q;
        deg_q  <= deg_rd_q;
      end
      OP_F_RD:      node_q <= i_idx;
      OP_F_CMP: begin
        if (trivial && chg_triv > worst_q) begin
          worst_q <= chg_triv;
        end
      end
      OP_F_TAKE: begin
        if (chg_div > worst_q) begin
          worst_q <= chg_div;
        end
      end
      OP_RESULT: begin
        rank_value_o      <= rank_val_q;
        iterations_used_o <= last_iter_q;
        converged_o       <= last_conv_q;
        status_o          <= status_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o.func        = func_q;
    sts_o.add_ok      = add_status == ST_OK;
    sts_o.clr_last    = i_q == NCNT_W'(NODE_MAX - 1);
    sts_o.node_last   = i_q == n_eff - 1'b1;
    sts_o.nodes_done  = i_q == n_eff;
    sts_o.edges_left  = e_q != total_q;
    sts_o.edge_skip   = ({1'b0, e_src} >= n_eff) || ({1'b0, e_dst} >= n_eff) ||
                        (e_src == e_dst);
    sts_o.deg_zero    = (deg_rd_q == '0) || (s_q == t_q);
    sts_o.cmp_trivial = trivial;
    sts_o.div_busy    = div_busy;
    sts_o.run_stop    = (worst_q <= tolerance_q) ||
                        (({1'b0, iter_q} + 17'd1) >= {1'b0, limit});
  end

endmodule

[hw/rtl/prp_ctrl.sv]
// ----------------------------------------------------------------------------
// prp_ctrl
// sequencer for graph edits, rank reads and the power iteration passes
// ----------------------------------------------------------------------------
module prp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output prp_pkg::dp_cmd_t cmd_o,
  input  prp_pkg::dp_sts_t sts_i
);
  import prp_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_ADD, S_ADD_WR, S_READ, S_READ_DONE,
    S_DIV_INIT, S_WAIT_INIT, S_DIV_BASE, S_WAIT_BASE, S_TAKE_BASE,
    S_INIT_RANK, S_PASS, S_ACC_INIT, S_E_RD, S_E_GET, S_E_MUL, S_E_DIV,
    S_E_WAIT, S_E_ACC, S_F_START, S_F_RD, S_F_CMP, S_F_WAIT, S_F_TAKE,
    S_PASS_END, S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   clr_resp_q, clr_resp_d;
  dp_op_e op;

  always_comb begin
    state_d    = state_q;
    clr_resp_d = clr_resp_q;
    op         = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        op = OP_CLR;
        if (sts_i.clr_last) begin
          state_d = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.func)
          FN_ADD:   state_d = S_ADD;
          FN_CLEAR: begin
            state_d    = S_CLEAR;
            clr_resp_d = 1'b1;
          end
          FN_RUN:   state_d = S_DIV_INIT;
          FN_READ:  state_d = S_READ;
          default:  state_d = S_RESP;
        endcase
      end
      S_ADD: begin
        op      = OP_ADD_CHK;
        state_d = sts_i.add_ok ? S_ADD_WR : S_RESP;
      end
      S_ADD_WR: begin
        op      = OP_ADD_WR;
        state_d = S_RESP;
      end
      S_READ: begin
        op      = OP_READ;
        state_d = S_READ_DONE;
      end
      S_READ_DONE: begin
        op      = OP_READ_DONE;
        state_d = S_RESP;
      end
      S_DIV_INIT: begin
        op      = OP_DIV_INIT;
        state_d = S_WAIT_INIT;
      end
      S_WAIT_INIT: if (!sts_i.div_busy) state_d = S_DIV_BASE;
      S_DIV_BASE: begin
        op      = OP_DIV_BASE;
        state_d = S_WAIT_BASE;
      end
      S_WAIT_BASE: if (!sts_i.div_busy) state_d = S_TAKE_BASE;
      S_TAKE_BASE: begin
        op      = OP_TAKE_BASE;
        state_d = S_INIT_RANK;
      end
      S_INIT_RANK: begin
        op = OP_INIT_RANK;
        if (sts_i.node_last) state_d = S_PASS;
      end
      S_PASS: begin
        op      = OP_PASS;
        state_d = S_ACC_INIT;
      end
      S_ACC_INIT: begin
        op = OP_ACC_INIT;
        if (sts_i.node_last) state_d = sts_i.edges_left ? S_E_RD : S_F_START;
      end
      S_E_RD: begin
        op      = OP_E_RD;
        state_d = S_E_GET;
      end
      S_E_GET: begin
        op = OP_E_GET;
        if (sts_i.edge_skip) begin
          state_d = sts_i.edges_left ? S_E_RD : S_F_START;
        end else begin
          state_d = S_E_MUL;
        end
      end
      S_E_MUL: begin
        op = OP_E_MUL;
        if (sts_i.deg_zero) begin
          state_d = sts_i.edges_left ? S_E_RD : S_F_START;
        end else begin
          state_d = S_E_DIV;
        end
      end
      S_E_DIV: begin
        op      = OP_E_DIV;
        state_d = S_E_WAIT;
      end
      S_E_WAIT: if (!sts_i.div_busy) state_d = S_E_ACC;
      S_E_ACC: begin
        op      = OP_E_ACC;
        state_d = sts_i.edges_left ? S_E_RD : S_F_START;
      end
      S_F_START: begin
        op      = OP_F_START;
        state_d = S_F_RD;
      end
      S_F_RD: begin
        op      = OP_F_RD;
        state_d = S_F_CMP;
      end
      S_F_CMP: begin
        op = OP_F_CMP;
        if (sts_i.cmp_trivial) begin
          state_d = sts_i.nodes_done ? S_PASS_END : S_F_RD;
        end else begin
          state_d = S_F_WAIT;
        end
      end
      S_F_WAIT: if (!sts_i.div_busy) state_d = S_F_TAKE;
      S_F_TAKE: begin
        op      = OP_F_TAKE;
        state_d = sts_i.nodes_done ? S_PASS_END : S_F_RD;
      end
      S_PASS_END: begin
        op      = OP_PASS_END;
        state_d = sts_i.run_stop ? S_RESP : S_PASS;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          op         = OP_RESULT;
          clr_resp_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      clr_resp_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_resp_q <= clr_resp_d;
      if (op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;

endmodule
